// File: hdl/pbac_pkg.sv
// Package for the accessory pak block access unit: payload word types, accessory
// and opcode codes, store geometry and the CRC-8 (poly 0x85) bit contribution table.
// No dependencies.
`default_nettype none

package pbac_pkg;

    // Store geometry
    localparam int PAK_BYTES  = 32768;
    localparam int BLK_BYTES  = 32;
    localparam int BLK_BITS   = BLK_BYTES * 8;
    localparam int PAK_ROWS   = PAK_BYTES / BLK_BYTES;
    localparam int ROW_W      = $clog2(PAK_ROWS);
    localparam int ADDR_W     = 16;
    localparam int ADDR_LSB   = $clog2(BLK_BYTES);
    localparam int ADDR_ROW_W = ADDR_W - ADDR_LSB;

    // Accessory codes
    localparam logic [1:0] ACC_NONE   = 2'd0;
    localparam logic [1:0] ACC_MEM    = 2'd1;
    localparam logic [1:0] ACC_RUMBLE = 2'd2;

    // Opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [7:0]          CRC_POLY    = 8'h85;
    localparam logic [BLK_BITS-1:0] RUMBLE_BLK  = {BLK_BYTES{8'h80}};

    // Source of the block seen by the result stage
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_RUMBLE,
        SRC_WRITE
    } t_src;

    typedef struct packed {
        logic        opcode;
        logic [15:0] block_address;
        logic [63:0] write_data_0;
        logic [63:0] write_data_1;
        logic [63:0] write_data_2;
        logic [63:0] write_data_3;
    } t_in_word;

    typedef struct packed {
        logic [63:0] read_data_0;
        logic [63:0] read_data_1;
        logic [63:0] read_data_2;
        logic [63:0] read_data_3;
        logic [7:0]  block_crc;
    } t_out_word;

    typedef logic [BLK_BITS-1:0][7:0] t_crc_tab;

    // One shift of the CRC register, MSB first
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic din);
        logic [7:0] nxt;
        nxt = {crc[6:0], din};
        if (crc[7]) begin
            nxt = nxt ^ CRC_POLY;
        end
        return nxt;
    endfunction

    // Contribution of each block bit to the final CRC (bit 0 is the last bit shifted in,
    // followed by the eight flush bits). The CRC is linear with zero start value.
    function automatic t_crc_tab crc_tab_build();
        t_crc_tab   tab;
        logic [7:0] v;
        v = crc_step(8'h00, 1'b1);
        for (int i = 0; i < 8; i++) begin
            v = crc_step(v, 1'b0);
        end
        tab[0] = v;
        for (int j = 1; j < BLK_BITS; j++) begin
            v      = crc_step(v, 1'b0);
            tab[j] = v;
        end
        return tab;
    endfunction

    localparam t_crc_tab CRC_TAB = crc_tab_build();

endpackage

`default_nettype wire

// File: hdl/pak_block_access_crc.sv
// Top level of the accessory pak block access unit with CRC-8 over each block.
// Depends on pbac_pkg (types, codes, store geometry, CRC table).
`default_nettype none

// Accessory pak block access with CRC-8.
//
// Input channel (i_valid / o_ready, word i_data): one 32-byte block read or write
// at a byte address aligned down to 32. Output channel (o_valid / i_ready, word
// o_data): one result word per input word, in order, carrying the read block
// (zero for a write) and a CRC-8 (poly 0x85, start 0, MSB first, 8 zero bits
// flushed) over the returned or written block.
// Configuration: i_cfg_we writes i_cfg_data into the accessory type register
// (none, memory pak, rumble pak; the unused code behaves as none).
//
// Timing: a word accepted at a clock edge is read from or written to the store at
// that edge; its result is loaded into the o_data register when the result stage advances.
// One word per cycle is sustained while results are taken: the store has one write
// and one registered read port, each used once per word, and the CRC is one XOR tree
// in the result stage. When the receiver stalls, the result register holds and the
// input stage fills; o_ready then drops until the result is taken.
// Reset: the store is swept to zero, one 32-byte row per cycle, over all PAK_ROWS
// rows (1024 for a 32 KiB pak). o_ready stays low during the sweep; configuration
// writes are taken throughout.
module pak_block_access_crc
    import pbac_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_word      o_data
);

    // Control registers
    logic [1:0]       r_acc;
    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;
    logic             r_s1_valid;
    logic             r_out_valid;

    // Payload registers
    t_src                r_s1_src;
    logic [BLK_BITS-1:0] r_s1_wdata;
    logic [BLK_BITS-1:0] r_rd_row;
    t_out_word           r_out;
    t_out_word           n_out;

    // Store: one 32-byte block per row
    logic [BLK_BITS-1:0] mem [PAK_ROWS];

    logic                accept;
    logic                s2_load;
    logic [ADDR_ROW_W:0] row_full;
    logic                fits;
    logic [ROW_W-1:0]    item_row;
    logic                mem_we;
    logic [ROW_W-1:0]    wr_idx;
    logic [BLK_BITS-1:0] wr_row;
    logic [BLK_BITS-1:0] in_blk;
    t_src                n_src;
    logic [BLK_BITS-1:0] blk;
    logic [7:0]          crc;

    // Handshake: advance the result stage when it is empty or being drained
    assign s2_load = r_s1_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_clr_busy & (~r_s1_valid | s2_load);
    assign accept  = i_valid & o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Address decode: drop the byte offset within the block
    assign row_full = {1'b0, i_data.block_address[ADDR_W-1:ADDR_LSB]};
    assign fits     = row_full < (ADDR_ROW_W + 1)'(PAK_ROWS);
    assign item_row = row_full[ROW_W-1:0];
    assign in_blk   = {i_data.write_data_0, i_data.write_data_1,
                       i_data.write_data_2, i_data.write_data_3};

    // Store write port, shared by the reset sweep and block writes
    always_comb begin
        if (r_clr_busy) begin
            mem_we = 1'b1;
            wr_idx = r_clr_row;
            wr_row = '0;
        end else begin
            mem_we = accept & (i_data.opcode == OP_WRITE) & (r_acc == ACC_MEM) & fits;
            wr_idx = item_row;
            wr_row = in_blk;
        end
    end

    // Pick where the block of this word comes from
    always_comb begin
        if (i_data.opcode == OP_WRITE) begin
            n_src = SRC_WRITE;
        end else begin
            unique case (r_acc)
                ACC_MEM:    n_src = fits ? SRC_MEM : SRC_ZERO;
                ACC_RUMBLE: n_src = SRC_RUMBLE;
                default:    n_src = SRC_ZERO;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_idx] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_row <= mem[item_row];
        end
    end

    // Result stage: select the block and fold it into the CRC
    always_comb begin
        unique case (r_s1_src)
            SRC_MEM:    blk = r_rd_row;
            SRC_RUMBLE: blk = RUMBLE_BLK;
            SRC_WRITE:  blk = r_s1_wdata;
            default:    blk = '0;
        endcase
        crc = '0;
        for (int j = 0; j < BLK_BITS; j++) begin
            crc = crc ^ (blk[j] ? CRC_TAB[j] : 8'h00);
        end
        n_out.block_crc = crc;
        if (r_s1_src == SRC_WRITE) begin
            n_out.read_data_0 = '0;
            n_out.read_data_1 = '0;
            n_out.read_data_2 = '0;
            n_out.read_data_3 = '0;
        end else begin
            n_out.read_data_0 = blk[255:192];
            n_out.read_data_1 = blk[191:128];
            n_out.read_data_2 = blk[127:64];
            n_out.read_data_3 = blk[63:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= ACC_NONE;
            r_clr_busy  <= 1'b1;
            r_clr_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_acc <= i_cfg_data;
            end
            if (r_clr_busy) begin
                if (r_clr_row == ROW_W'(PAK_ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_row <= r_clr_row + ROW_W'(1);
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src   <= n_src;
            r_s1_wdata <= in_blk;
        end
        if (s2_load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for pak_block_access_crc: directed table then random block reads and writes,
// each result checked against a fixed word or a behavioural model of store and CRC-8.
// Depends on pbac_pkg (word types, accessory and opcode codes, store size).
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import pbac_pkg::*;

    // Unused accessory code: must behave as no accessory
    localparam logic [1:0] ACC_UNUSED = 2'd3;

    localparam int MIRROR_WORDS = PAK_BYTES / 8;
    localparam int HOT_ROWS     = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;

    localparam logic [255:0] BLK_ZERO = '0;
    localparam logic [255:0] BLK_ONES = '1;
    localparam logic [255:0] BLK_PAT_A =
        256'h0123456789ABCDEF_FEDCBA9876543210_55AA55AA33CC33CC_8000000000000001;
    localparam logic [255:0] BLK_PAT_B =
        256'hDEADBEEFCAFEF00D_0F1E2D3C4B5A6978_FFFFFFFF00000000_7F7F7F7F80808080;
    localparam t_out_word RES_ZERO = '0;

    // One row of the directed table. Where 'fixed' is set the expected word is the one
    // in 'want'; otherwise the model works it out.
    typedef struct packed {
        logic [1:0]   acc;
        logic         op;
        logic [15:0]  addr;
        logic [255:0] data;
        logic         fixed;
        t_out_word    want;
    } t_dir_row;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // memory pak: store is clear after reset
        '{ACC_MEM,    OP_READ,  16'h0000, BLK_ZERO,  1'b1, RES_ZERO},
        // top address lies beyond the store: zero data
        '{ACC_MEM,    OP_READ,  16'hFFFF, BLK_ZERO,  1'b1, RES_ZERO},
        // low five address bits are dropped
        '{ACC_MEM,    OP_WRITE, 16'h001F, BLK_ONES,  1'b0, RES_ZERO},
        '{ACC_MEM,    OP_READ,  16'h0000, BLK_ZERO,  1'b0, RES_ZERO},
        // last block that fits
        '{ACC_MEM,    OP_WRITE, 16'h7FE0, BLK_PAT_A, 1'b0, RES_ZERO},
        '{ACC_MEM,    OP_READ,  16'h7FFF, BLK_ZERO,  1'b0, RES_ZERO},
        // first block that does not fit: write dropped, read zero
        '{ACC_MEM,    OP_WRITE, 16'h8000, BLK_PAT_B, 1'b0, RES_ZERO},
        '{ACC_MEM,    OP_READ,  16'h8000, BLK_ZERO,  1'b1, RES_ZERO},
        '{ACC_MEM,    OP_WRITE, 16'hFFFF, BLK_ONES,  1'b0, RES_ZERO},
        // write of a zero block: zero CRC
        '{ACC_MEM,    OP_WRITE, 16'h0000, BLK_ZERO,  1'b1, RES_ZERO},
        '{ACC_MEM,    OP_READ,  16'h001F, BLK_ZERO,  1'b1, RES_ZERO},
        // rumble pak: reads all 0x80, writes go nowhere
        '{ACC_RUMBLE, OP_READ,  16'h1234, BLK_ZERO,  1'b0, RES_ZERO},
        '{ACC_RUMBLE, OP_WRITE, 16'h0040, BLK_PAT_A, 1'b0, RES_ZERO},
        '{ACC_RUMBLE, OP_READ,  16'hFFE0, BLK_ZERO,  1'b0, RES_ZERO},
        // no accessory
        '{ACC_NONE,   OP_READ,  16'h7FE0, BLK_ZERO,  1'b1, RES_ZERO},
        '{ACC_NONE,   OP_WRITE, 16'h0020, BLK_PAT_B, 1'b0, RES_ZERO},
        // unused code behaves as no accessory
        '{ACC_UNUSED, OP_READ,  16'h7FE0, BLK_ZERO,  1'b1, RES_ZERO},
        '{ACC_UNUSED, OP_WRITE, 16'h0060, BLK_ONES,  1'b0, RES_ZERO},
        // back to the memory pak: only the memory pak writes stuck
        '{ACC_MEM,    OP_READ,  16'h7FE0, BLK_ZERO,  1'b0, RES_ZERO},
        '{ACC_MEM,    OP_READ,  16'h0060, BLK_ZERO,  1'b1, RES_ZERO},
        '{ACC_MEM,    OP_READ,  16'h0040, BLK_ZERO,  1'b1, RES_ZERO},
        '{ACC_MEM,    OP_READ,  16'h0020, BLK_ZERO,  1'b1, RES_ZERO}
    };

    // Random phases: accessory setting and idling regime of each
    localparam int PHASES         = 6;
    localparam int WORDS_PER_PHASE = 250;
    localparam logic [1:0] PHASE_ACC [PHASES] =
        '{ACC_MEM, ACC_RUMBLE, ACC_MEM, ACC_NONE, ACC_UNUSED, ACC_MEM};

    // DUT ports, inputs driven to known values from time zero
    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_data = ACC_NONE;
    logic      i_valid    = 1'b0;
    logic      o_ready;
    t_in_word  i_data     = '0;
    logic      o_valid;
    logic      i_ready    = 1'b0;
    t_out_word o_data;

    // Model state: mirror of the pak store and of the accessory register
    logic [63:0] store_mirror [MIRROR_WORDS];
    logic [1:0]  acc_mirror = ACC_NONE;

    // Results still owed by the block, oldest first
    t_out_word   pending_results [$];

    // Idling and long receiver hold-off
    int          snd_idle_pct = 29;
    int          rcv_idle_pct = 77;
    logic        hold_arm     = 1'b0;
    logic        hold_done    = 1'b0;
    int          hold_left    = 0;

    logic [9:0]  hot_rows [HOT_ROWS];

    // Bookkeeping
    int          fault_count   = 0;
    int          results_seen  = 0;
    int          reads_sent    = 0;
    int          writes_sent   = 0;
    int          writes_stored = 0;
    int          words_by_acc [4] = '{0, 0, 0, 0};

    pak_block_access_crc u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    always #10 i_clk = ~i_clk;

    // Run limit: far above the slowest correct run (reset sweep, heavy idling, long hold)
    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // CRC-8, poly 0x85, zero start, MSB of byte 0 first, then eight zero bits
    function automatic logic [7:0] block_crc8(input logic [255:0] blk);
        logic [7:0] crc;
        logic       msb;
        crc = 8'h00;
        for (int i = 255 + 8; i >= 0; i--) begin
            msb = crc[7];
            crc = {crc[6:0], (i >= 8) ? blk[i - 8] : 1'b0};
            if (msb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Result of one block access; a stored write updates the store mirror
    function automatic t_out_word pak_block_result(input t_in_word w);
        t_out_word    res;
        logic [255:0] blk;
        logic [15:0]  offs;
        logic         fits;
        int           base;
        offs = w.block_address & 16'hFFE0;
        fits = (int'(offs) + BLK_BYTES) <= PAK_BYTES;
        base = int'(offs) / 8;
        res  = '0;
        if (w.opcode == OP_WRITE) begin
            blk = {w.write_data_0, w.write_data_1, w.write_data_2, w.write_data_3};
            if (acc_mirror == ACC_MEM && fits) begin
                for (int k = 0; k < 4; k++) begin
                    store_mirror[base + k] = blk[255 - 64 * k -: 64];
                end
                writes_stored++;
            end
        end else begin
            blk = '0;
            if (acc_mirror == ACC_MEM && fits) begin
                blk = {store_mirror[base], store_mirror[base + 1],
                       store_mirror[base + 2], store_mirror[base + 3]};
            end else if (acc_mirror == ACC_RUMBLE) begin
                blk = {BLK_BYTES{8'h80}};
            end
            res.read_data_0 = blk[255:192];
            res.read_data_1 = blk[191:128];
            res.read_data_2 = blk[127:64];
            res.read_data_3 = blk[63:0];
        end
        res.block_crc = block_crc8(blk);
        return res;
    endfunction

    // Offer one word, with random idle cycles first; return at the edge that takes it.
    // Valid is left high so that a following word can go straight out.
    task automatic offer_word(input t_in_word w, input logic fixed, input t_out_word want);
        t_out_word pred;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pred = pak_block_result(w);
        pending_results.push_back(fixed ? want : pred);
        words_by_acc[acc_mirror]++;
        if (w.opcode == OP_WRITE) begin
            writes_sent++;
        end else begin
            reads_sent++;
        end
    endtask

    // Drop valid, let every owed result come back, then write the accessory register
    task automatic drain_and_set_acc(input logic [1:0] acc);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b1;
        i_cfg_data <= acc;
        acc_mirror  = acc;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random word: mostly a handful of hot rows so that reads find earlier writes,
    // some anywhere in the store, some anywhere in the address space
    function automatic t_in_word random_block_word();
        t_in_word w;
        int       pick;
        w.opcode = $urandom_range(1) ? OP_WRITE : OP_READ;
        pick = $urandom_range(99);
        if (pick < 70) begin
            w.block_address = {1'b0, hot_rows[$urandom_range(HOT_ROWS - 1)],
                               5'($urandom_range(31))};
        end else if (pick < 85) begin
            w.block_address = {1'b0, 15'($urandom_range(16'h7FFF))};
        end else begin
            w.block_address = 16'($urandom_range(16'hFFFF));
        end
        pick = $urandom_range(19);
        if (pick == 0) begin
            {w.write_data_0, w.write_data_1, w.write_data_2, w.write_data_3} = BLK_ONES;
        end else if (pick == 1) begin
            {w.write_data_0, w.write_data_1, w.write_data_2, w.write_data_3} = BLK_ZERO;
        end else begin
            w.write_data_0 = {$urandom, $urandom};
            w.write_data_1 = {$urandom, $urandom};
            w.write_data_2 = {$urandom, $urandom};
            w.write_data_3 = {$urandom, $urandom};
        end
        return w;
    endfunction

    task automatic note_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            fault_count++;
            if (fault_count <= REPORT_MAX) begin
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, fname,
                         want, got);
            end
        end
    endtask

    // Result side: check each word taken against the oldest expectation, then
    // decide ready for the next cycle (random idling, or the one long hold-off)
    always @(posedge i_clk) begin : result_side
        t_out_word want;
        if (o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX) begin
                    $display("%0t: result word with none expected: %h", $realtime, o_data);
                end
            end else begin
                want = pending_results.pop_front();
                note_field("read_data_0", want.read_data_0, o_data.read_data_0);
                note_field("read_data_1", want.read_data_1, o_data.read_data_1);
                note_field("read_data_2", want.read_data_2, o_data.read_data_2);
                note_field("read_data_3", want.read_data_3, o_data.read_data_3);
                note_field("block_crc", 64'(want.block_crc), 64'(o_data.block_crc));
            end
        end
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            // hold off long enough for the block to fill and drop o_ready
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial begin : stimulus
        t_in_word w;
        int       guard;
        foreach (store_mirror[k]) begin
            store_mirror[k] = '0;
        end
        hot_rows[0] = '0;
        hot_rows[1] = '1;
        for (int k = 2; k < HOT_ROWS; k++) begin
            hot_rows[k] = 10'($urandom_range(1023));
        end

        // Hold reset, then release it; the block then sweeps its store with o_ready low
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, under the first idling regime
        foreach (DIR_TAB[r]) begin
            if (r == 0 || DIR_TAB[r].acc != acc_mirror) begin
                drain_and_set_acc(DIR_TAB[r].acc);
            end
            w.opcode        = DIR_TAB[r].op;
            w.block_address = DIR_TAB[r].addr;
            {w.write_data_0, w.write_data_1, w.write_data_2, w.write_data_3} =
                DIR_TAB[r].data;
            offer_word(w, DIR_TAB[r].fixed, DIR_TAB[r].want);
        end

        // Random phases: two per idling regime, accessory changed between phases
        for (int p = 0; p < PHASES; p++) begin
            drain_and_set_acc(PHASE_ACC[p]);
            case (p / 2)
                0: begin
                    snd_idle_pct  = 29;
                    rcv_idle_pct <= 77;
                end
                1: begin
                    snd_idle_pct  = 77;
                    rcv_idle_pct <= 29;
                end
                default: begin
                    snd_idle_pct  = 0;
                    rcv_idle_pct <= 0;
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // last phase: start the long hold-off while words keep coming
                if (p == PHASES - 1 && n == 20) begin
                    hold_arm <= 1'b1;
                end
                offer_word(random_block_word(), 1'b0, RES_ZERO);
            end
        end
        i_valid <= 1'b0;

        // Wait for every owed result, with a limit
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            fault_count++;
            $display("%0d result words never arrived", pending_results.size());
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d reads and %0d writes (%0d stored); %0d result words checked.",
                 reads_sent, writes_sent, writes_stored, results_seen);
        $display("Words per accessory: none %0d, memory %0d, rumble %0d, unused code %0d.",
                 words_by_acc[0], words_by_acc[1], words_by_acc[2], words_by_acc[3]);
        if (fault_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", fault_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
